/* hdl/vtd_pkg.sv */
// ----------------------------------------------------------------------------
// vtd_pkg: shared types and constants of the varint TLV stream deframer
// Holds field widths, codes for result kinds, error codes and register indexes.
// ----------------------------------------------------------------------------
package vtd_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int ERR_W    = 3;
    localparam int FLEN_W   = 21;
    localparam int LEN_W    = 35;
    localparam int TIMER_W  = 32;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 32;
    localparam int GROUP_W  = 7;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_VERSION  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_VARINT   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_CLOSE    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVERSIZE = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_HEARTBEAT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAX_LEN   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_VERSION   = 2'd2;

    localparam logic [BYTE_W-1:0] TAG_PING     = 8'd0;
    localparam logic [BYTE_W-1:0] TAG_SHUTDOWN = 8'd4;

    localparam logic [TIMER_W-1:0] HEARTBEAT_RESET = 32'd600000;
    localparam logic [FLEN_W-1:0]  MAX_LEN_RESET   = 21'd8192;
    localparam logic [BYTE_W-1:0]  VERSION_RESET   = 8'd41;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [TIMER_W-1:0] heartbeat_interval_ms;
        logic [FLEN_W-1:0]  max_payload_len;
        logic [BYTE_W-1:0]  expected_version;
    } cfg_t;

endpackage

/* hdl/vtd_ifs.sv */
// ----------------------------------------------------------------------------
// vtd_ifs: channel interfaces of the varint TLV stream deframer
// Input items, result items and the configuration write channel.
// ----------------------------------------------------------------------------
interface vtd_item_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [vtd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface vtd_result_if;
    logic                       valid;
    logic                       ready;
    logic [vtd_pkg::KIND_W-1:0] kind;
    logic [vtd_pkg::BYTE_W-1:0] data_byte;
    logic [vtd_pkg::BYTE_W-1:0] frame_tag;
    logic [vtd_pkg::FLEN_W-1:0] frame_length;
    logic                       last_of_frame;
    logic                       send_ping;
    logic [vtd_pkg::ERR_W-1:0]  error_code;

    modport source (output valid, output kind, output data_byte, output frame_tag,
                    output frame_length, output last_of_frame, output send_ping,
                    output error_code, input ready);
    modport sink (input valid, input kind, input data_byte, input frame_tag,
                  input frame_length, input last_of_frame, input send_ping,
                  input error_code, output ready);
endinterface

interface vtd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [vtd_pkg::CIDX_W-1:0]  reg_index;
    logic [vtd_pkg::CDATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* hdl/vtd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// vtd_cfg_regs: configuration register file
// Holds the heartbeat interval, the payload length limit and the version.
// ----------------------------------------------------------------------------
module vtd_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    vtd_cfg_if.sink       cfg,
    output vtd_pkg::cfg_t cfg_q
);

    vtd_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heartbeat_interval_ms <= vtd_pkg::HEARTBEAT_RESET;
            cfg_reg.max_payload_len       <= vtd_pkg::MAX_LEN_RESET;
            cfg_reg.expected_version      <= vtd_pkg::VERSION_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                vtd_pkg::CFG_HEARTBEAT:
                    cfg_reg.heartbeat_interval_ms <= cfg.wdata;
                vtd_pkg::CFG_MAX_LEN:
                    cfg_reg.max_payload_len <= cfg.wdata[vtd_pkg::FLEN_W-1:0];
                vtd_pkg::CFG_VERSION:
                    cfg_reg.expected_version <= cfg.wdata[vtd_pkg::BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* hdl/vtd_in_stage.sv */
// ----------------------------------------------------------------------------
// vtd_in_stage: input register
// Captures one input transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module vtd_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    vtd_item_if.sink       rx,
    input  logic           take,
    output logic           item_valid,
    output vtd_pkg::item_t item
);

    logic           valid_reg;
    vtd_pkg::item_t item_reg;

    assign rx.ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            item_reg.mode    <= rx.mode;
            item_reg.rx_byte <= rx.rx_byte;
        end
    end

endmodule

/* hdl/vtd_core.sv */
// ----------------------------------------------------------------------------
// vtd_core: deframing state and result register
// Updates the stream phase, varint length and heartbeat timer for one
// registered item per cycle unless the result stalls; registers the result.
// ----------------------------------------------------------------------------
module vtd_core
#(
    parameter int MAX_VARINT_BYTES = 5
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  vtd_pkg::cfg_t  cfg_q,
    input  logic           item_valid,
    input  vtd_pkg::item_t item,
    output logic           take,
    vtd_result_if.source   res
);

    localparam int CW = $clog2(MAX_VARINT_BYTES + 1);

    typedef enum logic [2:0]
    {
        PH_VERSION,
        PH_TAG,
        PH_LEN,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [vtd_pkg::BYTE_W-1:0]    tag_reg, tag_next;
    logic [vtd_pkg::LEN_W-1:0]     accum_reg, accum_next;
    logic [CW-1:0]                 seen_reg, seen_next;
    logic [vtd_pkg::FLEN_W-1:0]    remain_reg, remain_next;
    logic [vtd_pkg::TIMER_W-1:0]   elapsed_reg, elapsed_next;
    logic [vtd_pkg::ERR_W-1:0]     err_reg, err_next;

    logic                          valid_reg;
    logic [vtd_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [vtd_pkg::BYTE_W-1:0]    data_reg, data_next;
    logic [vtd_pkg::BYTE_W-1:0]    ftag_reg;
    logic [vtd_pkg::FLEN_W-1:0]    flen_reg, flen_next;
    logic                          last_reg, last_next;
    logic                          ping_reg, ping_next;
    logic [vtd_pkg::ERR_W-1:0]     ecode_reg, ecode_next;

    logic [vtd_pkg::LEN_W-1:0]     group;
    logic [6:0]                    shamt;
    logic [vtd_pkg::LEN_W-1:0]     merged;
    logic [CW-1:0]                 seen_inc;
    logic [vtd_pkg::FLEN_W-1:0]    remain_dec;
    logic [vtd_pkg::TIMER_W-1:0]   elapsed_inc;

    assign take = item_valid && (!valid_reg || res.ready);

    assign res.valid         = valid_reg;
    assign res.kind          = kind_reg;
    assign res.data_byte     = data_reg;
    assign res.frame_tag     = ftag_reg;
    assign res.frame_length  = flen_reg;
    assign res.last_of_frame = last_reg;
    assign res.send_ping     = ping_reg;
    assign res.error_code    = ecode_reg;

    always_comb
    begin
        group = {{(vtd_pkg::LEN_W - vtd_pkg::GROUP_W){1'b0}},
                 item.rx_byte[vtd_pkg::GROUP_W-1:0]};
        shamt = 7'(seen_reg) * 7'(vtd_pkg::GROUP_W);
        if (group == '0)
            merged = accum_reg;
        else if (shamt >= 7'(vtd_pkg::LEN_W))
            merged = '1;
        else
            merged = accum_reg | (group << shamt);
        seen_inc    = seen_reg + CW'(1);
        remain_dec  = (remain_reg != '0) ? remain_reg - vtd_pkg::FLEN_W'(1) : remain_reg;
        elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + vtd_pkg::TIMER_W'(1)
                                          : elapsed_reg;

        phase_next   = phase_reg;
        tag_next     = tag_reg;
        accum_next   = accum_reg;
        seen_next    = seen_reg;
        remain_next  = remain_reg;
        elapsed_next = elapsed_reg;
        err_next     = err_reg;
        kind_next    = vtd_pkg::KIND_HEADER;
        data_next    = '0;
        last_next    = 1'b0;
        ping_next    = 1'b0;
        ecode_next   = vtd_pkg::ERR_NONE;

        if (phase_reg == PH_HALT)
        begin
            kind_next  = vtd_pkg::KIND_ERROR;
            ecode_next = err_reg;
        end
        else if (item.mode)
        begin
            kind_next = vtd_pkg::KIND_TICK;
            if (elapsed_inc > cfg_q.heartbeat_interval_ms)
            begin
                ping_next    = 1'b1;
                elapsed_next = '0;
            end
            else
            begin
                elapsed_next = elapsed_inc;
            end
        end
        else
        begin
            case (phase_reg)
                PH_VERSION:
                begin
                    if (item.rx_byte != cfg_q.expected_version)
                        ecode_next = vtd_pkg::ERR_VERSION;
                    else
                        phase_next = PH_TAG;
                end
                PH_TAG:
                begin
                    tag_next    = item.rx_byte;
                    accum_next  = '0;
                    seen_next   = '0;
                    remain_next = '0;
                    phase_next  = PH_LEN;
                end
                PH_LEN:
                begin
                    accum_next = merged;
                    seen_next  = seen_inc;
                    if (item.rx_byte[vtd_pkg::BYTE_W-1])
                    begin
                        if (seen_inc >= CW'(MAX_VARINT_BYTES))
                            ecode_next = vtd_pkg::ERR_VARINT;
                    end
                    else if (merged > vtd_pkg::LEN_W'(cfg_q.max_payload_len))
                    begin
                        ecode_next = vtd_pkg::ERR_OVERSIZE;
                    end
                    else if (merged == '0)
                    begin
                        last_next = 1'b1;
                        if (tag_reg == vtd_pkg::TAG_SHUTDOWN)
                        begin
                            ecode_next = vtd_pkg::ERR_CLOSE;
                        end
                        else
                        begin
                            kind_next  = vtd_pkg::KIND_EMPTY;
                            ping_next  = (tag_reg == vtd_pkg::TAG_PING);
                            phase_next = PH_TAG;
                        end
                    end
                    else
                    begin
                        remain_next = merged[vtd_pkg::FLEN_W-1:0];
                        phase_next  = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    remain_next = remain_dec;
                    kind_next   = vtd_pkg::KIND_PAYLOAD;
                    data_next   = item.rx_byte;
                    if (remain_dec == '0)
                    begin
                        last_next = 1'b1;
                        if (tag_reg == vtd_pkg::TAG_SHUTDOWN)
                        begin
                            ecode_next = vtd_pkg::ERR_CLOSE;
                        end
                        else
                        begin
                            ping_next  = (tag_reg == vtd_pkg::TAG_PING);
                            phase_next = PH_TAG;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (ecode_next != vtd_pkg::ERR_NONE)
            begin
                kind_next  = vtd_pkg::KIND_ERROR;
                data_next  = '0;
                ping_next  = 1'b0;
                err_next   = ecode_next;
                phase_next = PH_HALT;
            end
        end

        if (accum_next[vtd_pkg::LEN_W-1:vtd_pkg::FLEN_W] != '0)
            flen_next = '1;
        else
            flen_next = accum_next[vtd_pkg::FLEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_VERSION;
            tag_reg     <= '0;
            accum_reg   <= '0;
            seen_reg    <= '0;
            remain_reg  <= '0;
            elapsed_reg <= '0;
            err_reg     <= vtd_pkg::ERR_NONE;
            valid_reg   <= 1'b0;
            kind_reg    <= vtd_pkg::KIND_HEADER;
            data_reg    <= '0;
            ftag_reg    <= '0;
            flen_reg    <= '0;
            last_reg    <= 1'b0;
            ping_reg    <= 1'b0;
            ecode_reg   <= vtd_pkg::ERR_NONE;
        end
        else
        begin
            if (take)
            begin
                phase_reg   <= phase_next;
                tag_reg     <= tag_next;
                accum_reg   <= accum_next;
                seen_reg    <= seen_next;
                remain_reg  <= remain_next;
                elapsed_reg <= elapsed_next;
                err_reg     <= err_next;
                valid_reg   <= 1'b1;
                kind_reg    <= kind_next;
                data_reg    <= data_next;
                ftag_reg    <= tag_next;
                flen_reg    <= flen_next;
                last_reg    <= last_next;
                ping_reg    <= ping_next;
                ecode_reg   <= ecode_next;
            end
            else if (res.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // An error code appears exactly on error results.
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ((res.kind == vtd_pkg::KIND_ERROR) ==
                       (res.error_code != vtd_pkg::ERR_NONE)))
        else $error("error code and result kind disagree");

    // The halted phase is never left without a reset.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("left the halted phase");

    // A frame in its payload always has bytes left to receive.
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with nothing remaining");

    // The varint byte count stays below its limit while the length arrives.
    a_varint_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEN |-> seen_reg < CW'(MAX_VARINT_BYTES))
        else $error("varint byte count at its limit in the length phase");

    // The last marker only closes a frame.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.last_of_frame) |->
            (res.kind == vtd_pkg::KIND_PAYLOAD || res.kind == vtd_pkg::KIND_EMPTY ||
             res.kind == vtd_pkg::KIND_ERROR))
        else $error("last marker on a result that ends no frame");

endmodule

/* hdl/varint_tlv_stream_deframer_unit.sv */
// ----------------------------------------------------------------------------
// varint_tlv_stream_deframer_unit: varint TLV stream deframer
// Checks the stream version byte, splits tag, varint length and payload of
// each frame, raises ping requests and halts on protocol errors.
//
//   Channel  Direction  Payload
//   rx       in         mode, rx_byte
//   res      out        kind, data_byte, frame_tag, frame_length,
//                       last_of_frame, send_ping, error_code
//   cfg      in         reg_index, wdata
//
// One transaction is accepted per cycle into the input register while it is
// free or its item is being taken; the core then loads the result into its
// result register, from which the result can be taken.
// The state update in the core is a loop through its state registers.
// Reset clears the phase, frame state and timer and loads register defaults.
// A stalled result register holds the next item in the input register, so
// rx.ready drops only when both registers are full.
// ----------------------------------------------------------------------------
module varint_tlv_stream_deframer_unit
#(
    parameter int MAX_VARINT_BYTES = 5
)
(
    input  logic         clk,
    input  logic         rst_n,
    vtd_item_if.sink     rx,
    vtd_result_if.source res,
    vtd_cfg_if.sink      cfg
);

    vtd_pkg::cfg_t  cfg_q;
    vtd_pkg::item_t item;
    logic           item_valid;
    logic           take;

    vtd_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    vtd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    vtd_core
    #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_q      (cfg_q),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res        (res)
    );

endmodule
